FILE: sv/time_block_range_lookup_top_assert.svh
// Assertion macros shared by the interval lookup RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TIME_BLOCK_RANGE_LOOKUP_TOP_ASSERT_SVH
`define TIME_BLOCK_RANGE_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TBRL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TBRL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tbrl_pkg.sv
// Shared types and codes for the interval table with range lookup.
// Depends on nothing; used by tbrl_ctrl and the top level.
package tbrl_pkg;

  localparam int TIME_W = 64;
  localparam int IDX_W  = 11;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    idx_t first_index;
    idx_t stop_index;
    logic status;
  } result_t;

endpackage

FILE: sv/time_block_range_lookup_top.sv
// Top level of the interval table with range lookup.
// Depends on tbrl_pkg, tbrl_ctrl and tbrl_ram.
//
// Usage: the request channel (in_valid / in_ready) carries kind, time_begin and
// time_end. An append request stores [time_begin, time_end) at the next free
// index, or is dropped with status full once MAX_INTERVALS entries are held. A
// query request binary-searches for the first interval whose end exceeds the
// range begin, then scans forward while interval begins lie below the range end.
// Every request gives exactly one response on the out_valid / out_ready channel.
//
// Timing: one request is in work at a time. An append passes the APPEND state
// and then DONE, where its response is loaded. A query runs the binary search,
// then the forward scan, then DONE; each halving step and each scanned interval
// is one registered RAM read and a compare, and the scan reads one more interval
// when it stops on a non-overlapping one. The next request is taken the cycle
// after a response is loaded, so a new request is never taken before the last
// one is through. Reset zeroes the entry count; store contents are kept. A stalled
// receiver does not block the next request; the block then holds that request's
// response until the output register is free.
module time_block_range_lookup_top #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [tbrl_pkg::TIME_W-1:0] time_begin,
  input  logic signed [tbrl_pkg::TIME_W-1:0] time_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tbrl_pkg::idx_t                     first_index,
  output tbrl_pkg::idx_t                     stop_index,
  output logic                               status
);

  localparam int ADDR_W = $clog2(MAX_INTERVALS);

  // Store write and read ports, driven by the sequencer.
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [tbrl_pkg::TIME_W-1:0]   wr_begin;
  logic [tbrl_pkg::TIME_W-1:0]   wr_end;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic [tbrl_pkg::TIME_W-1:0]   rd_begin;
  logic [tbrl_pkg::TIME_W-1:0]   rd_end;

  // Finished response from the sequencer and the output register.
  logic              res_valid;
  logic              res_ready;
  tbrl_pkg::result_t res;
  tbrl_pkg::result_t out_res;

  tbrl_ctrl #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .time_begin (time_begin),
    .time_end   (time_end),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_begin   (wr_begin),
    .wr_end     (wr_end),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_begin   (rd_begin),
    .rd_end     (rd_end),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Interval begins; read by the forward scan.
  tbrl_ram #(
    .WIDTH (tbrl_pkg::TIME_W),
    .DEPTH (MAX_INTERVALS)
  ) u_begin_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_begin),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_begin)
  );

  // Interval ends; read by the binary search.
  tbrl_ram #(
    .WIDTH (tbrl_pkg::TIME_W),
    .DEPTH (MAX_INTERVALS)
  ) u_end_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_end),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_end)
  );

  // The output register takes a new response when it is empty or being drained.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign first_index = out_res.first_index;
  assign stop_index  = out_res.stop_index;
  assign status      = out_res.status;

endmodule

FILE: sv/tbrl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; instanced once per interval store.
module tbrl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/tbrl_ctrl.sv
// Sequencer for appends, the binary search and the forward scan.
// Depends on tbrl_pkg and the assertion header; drives the two store RAMs.
`include "time_block_range_lookup_top_assert.svh"

module tbrl_ctrl #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    kind,
  input  logic signed [tbrl_pkg::TIME_W-1:0]      time_begin,
  input  logic signed [tbrl_pkg::TIME_W-1:0]      time_end,
  output logic                                    wr_en,
  output logic [$clog2(MAX_INTERVALS)-1:0]        wr_addr,
  output logic [tbrl_pkg::TIME_W-1:0]             wr_begin,
  output logic [tbrl_pkg::TIME_W-1:0]             wr_end,
  output logic                                    rd_en,
  output logic [$clog2(MAX_INTERVALS)-1:0]        rd_addr,
  input  logic [tbrl_pkg::TIME_W-1:0]             rd_begin,
  input  logic [tbrl_pkg::TIME_W-1:0]             rd_end,
  output logic                                    res_valid,
  input  logic                                    res_ready,
  output tbrl_pkg::result_t                       res
);

  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int ADDR_W = $clog2(MAX_INTERVALS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SEARCH,
    ST_SEARCH_CMP,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_DONE
  } state_t;

  state_t                             state;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   lo;
  logic [CNT_W-1:0]                   len;
  logic [CNT_W-1:0]                   stop;
  logic signed [tbrl_pkg::TIME_W-1:0] key_begin;
  logic signed [tbrl_pkg::TIME_W-1:0] key_end;

  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] mid;
  logic             full;
  logic             scan_more;

  assign half      = len >> 1;
  assign mid       = lo + half;
  assign full      = (count >= CNT_W'(MAX_INTERVALS));
  assign scan_more = (stop < count);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign wr_en    = (state == ST_APPEND) && !full;
  assign wr_addr  = count[ADDR_W-1:0];
  assign wr_begin = key_begin;
  assign wr_end   = key_end;

  assign rd_en   = ((state == ST_SEARCH) && (len != '0)) || ((state == ST_SCAN) && scan_more);
  assign rd_addr = (state == ST_SEARCH) ? mid[ADDR_W-1:0] : stop[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key_begin <= time_begin;
            key_end   <= time_end;
            lo        <= '0;
            len       <= count;
            state     <= (kind == tbrl_pkg::KIND_APPEND) ? ST_APPEND : ST_SEARCH;
          end
        end
        ST_APPEND: begin
          if (full) begin
            res.first_index <= tbrl_pkg::idx_t'(count);
            res.stop_index  <= tbrl_pkg::idx_t'(count);
            res.status      <= tbrl_pkg::STATUS_FULL;
          end else begin
            res.first_index <= tbrl_pkg::idx_t'(count);
            res.stop_index  <= tbrl_pkg::idx_t'(count + CNT_W'(1));
            res.status      <= tbrl_pkg::STATUS_OK;
            count           <= count + CNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_SEARCH: begin
          if (len == '0) begin
            stop  <= lo;
            state <= ST_SCAN;
          end else begin
            state <= ST_SEARCH_CMP;
          end
        end
        ST_SEARCH_CMP: begin
          if ($signed(rd_end) <= key_begin) begin
            lo  <= mid + CNT_W'(1);
            len <= len - half - CNT_W'(1);
          end else begin
            len <= half;
          end
          state <= ST_SEARCH;
        end
        ST_SCAN: begin
          if (scan_more) begin
            state <= ST_SCAN_CMP;
          end else begin
            res.first_index <= tbrl_pkg::idx_t'(lo);
            res.stop_index  <= tbrl_pkg::idx_t'(stop);
            res.status      <= tbrl_pkg::STATUS_OK;
            state           <= ST_DONE;
          end
        end
        ST_SCAN_CMP: begin
          if ($signed(rd_begin) < key_end) begin
            stop  <= stop + CNT_W'(1);
            state <= ST_SCAN;
          end else begin
            res.first_index <= tbrl_pkg::idx_t'(lo);
            res.stop_index  <= tbrl_pkg::idx_t'(stop);
            res.status      <= tbrl_pkg::STATUS_OK;
            state           <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The table never grows past its depth, and a full table is never written.
  `TBRL_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_INTERVALS), "count over depth")
  `TBRL_ASSERT_IMP(a_no_write_full, clk, rst, wr_en, !full, "write into a full table")
  // The search window always stays inside the filled part of the table.
  `TBRL_ASSERT_IMP(a_window, clk, rst, (state == ST_SEARCH) || (state == ST_SEARCH_CMP), ({1'b0, lo} + {1'b0, len}) <= {1'b0, count}, "search window past count")
  // The scan starts at the search answer and never runs past the count.
  `TBRL_ASSERT_IMP(a_scan_span, clk, rst, (state == ST_SCAN) || (state == ST_SCAN_CMP), (stop >= lo) && (stop <= count), "scan index out of span")
  // Every scan read of an entry below the count is followed by its compare.
  `TBRL_ASSERT_NXT(a_scan_read, clk, rst, (state == ST_SCAN) && scan_more, state == ST_SCAN_CMP, "scan compare skipped")

endmodule

FILE: tb/tbrl_response_checker.sv
`timescale 1ns / 1ps
// Response checker for the interval table with range lookup: mirrors the table,
// predicts every response and compares it. Depends on tbrl_pkg.
module tbrl_response_checker #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               kind,
  input  logic signed [tbrl_pkg::TIME_W-1:0] time_begin,
  input  logic signed [tbrl_pkg::TIME_W-1:0] time_end,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  tbrl_pkg::idx_t                     first_index,
  input  tbrl_pkg::idx_t                     stop_index,
  input  logic                               status,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 stored_count,
  output int                                 refused_count,
  output int                                 query_count,
  output int                                 checked_count
);
  import tbrl_pkg::*;

  localparam int SHOW_LIMIT = 100;

  logic signed [TIME_W-1:0] span_begin [MAX_INTERVALS];
  logic signed [TIME_W-1:0] span_end   [MAX_INTERVALS];
  int unsigned              span_count;
  result_t                  pending_responses [$];
  int                       shown;

  // Applies one request to the mirrored table and returns its response.
  function automatic result_t lookup_response(input logic req_kind,
                                              input logic signed [TIME_W-1:0] req_begin,
                                              input logic signed [TIME_W-1:0] req_end);
    result_t     r;
    int unsigned lo, len, half, mid, stop;
    r.status = STATUS_OK;
    if (req_kind == KIND_APPEND) begin
      if (span_count >= MAX_INTERVALS) begin
        r.first_index = idx_t'(span_count);
        r.stop_index  = idx_t'(span_count);
        r.status      = STATUS_FULL;
      end else begin
        span_begin[span_count] = req_begin;
        span_end[span_count]   = req_end;
        r.first_index = idx_t'(span_count);
        span_count++;
        r.stop_index  = idx_t'(span_count);
      end
    end else begin
      lo  = 0;
      len = span_count;
      while (len > 0) begin
        half = len / 2;
        mid  = lo + half;
        if (span_end[mid] <= req_begin) begin
          lo  = mid + 1;
          len = len - (half + 1);
        end else begin
          len = half;
        end
      end
      stop = lo;
      while (stop < span_count && span_begin[stop] < req_end) stop++;
      r.first_index = idx_t'(lo);
      r.stop_index  = idx_t'(stop);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      span_count = 0;
      pending_responses.delete();
      fail_count    = 0;
      outstanding   = 0;
      stored_count  = 0;
      refused_count = 0;
      query_count   = 0;
      checked_count = 0;
      shown         = 0;
    end else begin
      // A response always belongs to an earlier request, so it is retired first.
      if (out_valid && out_ready) begin
        got.first_index = first_index;
        got.stop_index  = stop_index;
        got.status      = status;
        if (pending_responses.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t: response with no request waiting: first=%0d stop=%0d status=%0d",
                     $time, got.first_index, got.stop_index, got.status);
          end
        end else begin
          want = pending_responses.pop_front();
          checked_count++;
          if (got.first_index !== want.first_index || got.stop_index !== want.stop_index ||
              got.status !== want.status) begin
            fail_count++;
            if (shown < SHOW_LIMIT) begin
              shown++;
              $display("%0t: mismatch: expected first=%0d stop=%0d status=%0d, actual first=%0d stop=%0d status=%0d",
                       $time, want.first_index, want.stop_index, want.status,
                       got.first_index, got.stop_index, got.status);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = lookup_response(kind, time_begin, time_end);
        pending_responses.insert(pending_responses.size(), want);
        if (kind == KIND_QUERY) query_count++;
        else if (want.status == STATUS_FULL) refused_count++;
        else stored_count++;
      end
      outstanding = pending_responses.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the interval table with range lookup: clock, reset,
// request stimulus, response back-pressure and verdict. Depends on tbrl_pkg,
// time_block_range_lookup_top and tbrl_response_checker.
module tb;
  import tbrl_pkg::*;

  localparam int MAX_INTERVALS   = 1024;
  localparam int RANDOM_REQUESTS = 1250;
  // The slowest request is a query that scans the whole table, plus the
  // longest receiver stall. The limit is many times that.
  localparam int IDLE_LIMIT      = 20000;
  localparam int DRAIN_CYCLES    = 100;

  localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     kind;
  logic signed [TIME_W-1:0] time_begin;
  logic signed [TIME_W-1:0] time_end;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  idx_t                     first_index;
  idx_t                     stop_index;
  logic                     status;

  int fail_count;
  int outstanding;
  int stored_count;
  int refused_count;
  int query_count;
  int checked_count;

  // Stimulus state: the sorted intervals start at a random base and grow
  // upward from there, so queries can be aimed at the populated time window.
  logic signed [TIME_W-1:0] base_time;
  logic signed [TIME_W-1:0] cursor_time;
  int                       appends_sent;
  bit                       send_calm;
  bit                       recv_calm;
  int                       ready_hold;
  int                       idle_cycles;

  time_block_range_lookup_top #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .time_begin (time_begin),
    .time_end   (time_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .first_index(first_index),
    .stop_index (stop_index),
    .status     (status)
  );

  tbrl_response_checker #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) response_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .time_begin   (time_begin),
    .time_end     (time_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_index  (first_index),
    .stop_index   (stop_index),
    .status       (status),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .stored_count (stored_count),
    .refused_count(refused_count),
    .query_count  (query_count),
    .checked_count(checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length in cycles: mostly none or short, now and then long. In a calm
  // stretch there is no idling at all.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one request after a random gap and holds it until it is taken.
  // Valid is only lowered when a gap actually follows, so a back-to-back
  // request never sees valid drop and rise in the same time step.
  task automatic send_request(input logic req_kind,
                              input logic signed [TIME_W-1:0] req_begin,
                              input logic signed [TIME_W-1:0] req_end);
    int gap;
    gap = pick_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= req_kind;
    time_begin <= req_begin;
    time_end   <= req_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req_kind == KIND_APPEND) appends_sent++;
  endtask

  // One random request. Most appends continue the sorted sequence, with some
  // zero-length and reversed intervals; queries mostly hit the populated
  // window with narrow ranges, a few are empty, reversed or span everything.
  // A small share is raw noise over the full 64-bit range.
  task automatic random_request();
    logic signed [TIME_W-1:0] b;
    logic signed [TIME_W-1:0] e;
    logic                     k;
    int unsigned              window;
    int                       r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      k = $urandom_range(0, 1);
      b = {$urandom, $urandom};
      e = {$urandom, $urandom};
    end else if (r < 80) begin
      k = KIND_APPEND;
      if ($urandom_range(0, 9) != 0) cursor_time = cursor_time + $urandom_range(1, 400);
      b = cursor_time;
      r = $urandom_range(0, 99);
      if (r < 5) e = b - $urandom_range(1, 500);
      else if (r < 8) e = b;
      else e = b + $urandom_range(1, 1500);
    end else begin
      k = KIND_QUERY;
      window = 32'(cursor_time - base_time) + 2000;
      b = base_time - 1000 + $urandom_range(0, window);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        e = b - $urandom_range(1, 2000);
      end else if (r < 10) begin
        e = b;
      end else if (r < 12) begin
        b = T_MIN;
        e = T_MAX;
      end else if (r < 14) begin
        b = base_time - $urandom_range(0, 1000);
        e = cursor_time + $urandom_range(0, 1000);
      end else begin
        e = b + $urandom_range(1, 3000);
      end
    end
    send_request(k, b, e);
  endtask

  // Response back-pressure: ready toggles between short ready stretches and
  // random stalls; calm stretches keep it high throughout.
  always @(negedge clk) begin
    int stall;
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_ready) begin
      stall = pick_gap(recv_calm);
      if (stall > 0) begin
        out_ready  <= 1'b0;
        ready_hold = stall - 1;
      end else begin
        ready_hold = $urandom_range(0, 6);
      end
      if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
    end else begin
      out_ready  <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end
  end

  // Watchdog: a run in which neither channel moves for too long is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                 $time, IDLE_LIMIT, outstanding);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_APPEND;
    time_begin   = '0;
    time_end     = '0;
    appends_sent = 0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    ready_hold   = 0;
    idle_cycles  = 0;
    base_time    = $signed({$urandom, $urandom}) >>> 2;
    cursor_time  = base_time;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Queries on the empty table come first, then intervals at
    // the extremes of the time range, a zero-length and a reversed one, then
    // queries with full, empty, reversed and extreme ranges.
    send_request(KIND_QUERY, T_MIN, T_MAX);
    send_request(KIND_QUERY, T_MAX, T_MIN);
    send_request(KIND_APPEND, T_MIN, T_MIN);
    send_request(KIND_APPEND, T_MIN, T_MAX);
    send_request(KIND_APPEND, -64'sd200, -64'sd300);
    send_request(KIND_APPEND, -64'sd200, 64'sd100);
    send_request(KIND_APPEND, 64'sd0, 64'sd0);
    send_request(KIND_APPEND, T_MAX, T_MAX);
    send_request(KIND_QUERY, T_MIN, T_MAX);
    send_request(KIND_QUERY, T_MIN, T_MIN);
    send_request(KIND_QUERY, T_MAX, T_MAX);
    send_request(KIND_QUERY, T_MAX, T_MIN);
    send_request(KIND_QUERY, -64'sd250, -64'sd250);
    send_request(KIND_QUERY, -64'sd250, -64'sd199);
    send_request(KIND_QUERY, 64'sd50, -64'sd50);
    send_request(KIND_QUERY, -64'sd1, 64'sd1);
    send_request(KIND_QUERY, 64'sd0, 64'sd1);
    send_request(KIND_QUERY, T_MAX - 1, T_MAX);

    // Random part. It runs on past the nominal count until the table has
    // overflowed, so refused appends and queries on a full table both occur.
    for (int n = 0; n < RANDOM_REQUESTS || appends_sent < MAX_INTERVALS + 12; n++) begin
      if (n % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_REQUESTS / 2) begin
        // Hold the sender back until every response so far has come out.
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      random_request();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d stored appends (table of %0d), %0d appends refused as full,",
             stored_count, MAX_INTERVALS, refused_count);
    $display("and %0d range queries; %0d responses were checked.", query_count, checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
